[src/dtd_pkg.sv]
// Shared constants and types for the dirty tile detector.
package dtd_pkg;

  localparam int TILE_BITS      = 10;
  localparam int BYTE_BITS      = 8;
  localparam int DATA_BITS      = 8;
  localparam int COUNT_BITS     = 11;
  localparam int FRAME_BITS     = 32;
  localparam int NUM_TILES      = 1 << TILE_BITS;
  localparam int BYTES_PER_TILE = 1 << BYTE_BITS;
  localparam int STORE_DEPTH    = NUM_TILES * BYTES_PER_TILE;
  localparam int QDEPTH         = 4;
  localparam int QPTR_BITS      = $clog2(QDEPTH);
  localparam int QCNT_BITS      = $clog2(QDEPTH + 1) + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
  localparam logic [FRAME_BITS-1:0] FRAME_FIRST = FRAME_BITS'(1);

  typedef struct packed {
    logic [TILE_BITS-1:0] tile;
    logic                 changed;
    logic                 frame_end;
  } dtd_rec_t;

endpackage

[src/dtd_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module dtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/dtd_front.sv]
// Front end: accepts bytes, compares them with the previous frame and classifies tiles.
module dtd_front
  import dtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [TILE_BITS-1:0]  tile_number,
  input  logic [BYTE_BITS-1:0]  byte_offset,
  input  logic [DATA_BITS-1:0]  pixel_byte,
  input  logic                  tile_end,
  input  logic                  frame_end,
  input  logic [QCNT_BITS-1:0]  q_level,
  output logic                  rec_push,
  output dtd_rec_t              rec
);

  logic                 accept;
  logic                 clearing;
  logic [TILE_BITS-1:0] clr_idx;
  logic                 s1_valid;
  logic [TILE_BITS-1:0] s1_tile;
  logic [DATA_BITS-1:0] s1_data;
  logic                 s1_end;
  logic                 s1_fend;
  logic                 diff_seen;
  logic                 diff_seen_next;
  logic [DATA_BITS-1:0] old_byte;
  logic [0:0]           old_valid;
  logic                 byte_diff;
  logic                 valid_we;
  logic [TILE_BITS-1:0] valid_waddr;
  logic [0:0]           valid_wdata;
  logic [QCNT_BITS-1:0] q_claimed;

  // Items in flight in the compare stage hold a queue slot in advance.
  assign q_claimed = q_level + QCNT_BITS'(s1_valid);
  assign full      = clearing || (q_claimed >= QCNT_BITS'(QDEPTH));
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + TILE_BITS'(1);
      if (clr_idx == TILE_BITS'(NUM_TILES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  dtd_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept),
    .waddr({tile_number, byte_offset}),
    .wdata(pixel_byte),
    .raddr({tile_number, byte_offset}),
    .rdata(old_byte)
  );

  assign valid_we    = clearing || (accept && (tile_end || frame_end));
  assign valid_waddr = clearing ? clr_idx : tile_number;
  assign valid_wdata = clearing ? 1'b0 : 1'b1;

  dtd_ram #(
    .WIDTH(1),
    .DEPTH(NUM_TILES)
  ) u_valid (
    .clk  (clk),
    .we   (valid_we),
    .waddr(valid_waddr),
    .wdata(valid_wdata),
    .raddr(tile_number),
    .rdata(old_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tile <= tile_number;
      s1_data <= pixel_byte;
      s1_end  <= tile_end || frame_end;
      s1_fend <= frame_end;
    end
  end

  assign byte_diff = old_valid[0] && (old_byte != s1_data);

  always_comb begin
    diff_seen_next = diff_seen;
    if (s1_valid) begin
      diff_seen_next = s1_end ? 1'b0 : (diff_seen || byte_diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_seen <= 1'b0;
    end else begin
      diff_seen <= diff_seen_next;
    end
  end

  assign rec_push      = s1_valid && s1_end;
  assign rec.tile      = s1_tile;
  assign rec.changed   = !old_valid[0] || diff_seen || byte_diff;
  assign rec.frame_end = s1_fend;

endmodule

[src/dtd_queue.sv]
// Short queue of tile records between the front end and the back end.
module dtd_queue
  import dtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  dtd_rec_t             wr_rec,
  input  logic                 rd_en,
  output dtd_rec_t             head,
  output logic                 not_empty,
  output logic [QCNT_BITS-1:0] level
);

  dtd_rec_t             slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;

  assign head      = slots[rd_ptr];
  assign not_empty = (level != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      level <= level + QCNT_BITS'(wr_en) - QCNT_BITS'(rd_en);
    end
  end

endmodule

[src/dtd_back.sv]
// Back end: counts changed tiles and frames and holds the result register.
module dtd_back
  import dtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dtd_rec_t              head,
  input  logic                  q_valid,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [TILE_BITS-1:0]  tile_id,
  output logic                  tile_changed,
  output logic                  frame_done,
  output logic [COUNT_BITS-1:0] frame_changes,
  output logic [FRAME_BITS-1:0] frame_number
);

  logic                  out_valid;
  logic [COUNT_BITS-1:0] change_count;
  logic [COUNT_BITS-1:0] count_next;
  logic [FRAME_BITS-1:0] frame_counter;

  assign q_pop = q_valid && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    count_next = change_count;
    if (head.changed && (change_count != COUNT_MAX)) begin
      count_next = change_count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      change_count  <= '0;
      frame_counter <= FRAME_FIRST;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (head.frame_end) begin
          change_count  <= '0;
          frame_counter <= (frame_counter == FRAME_MAX) ? FRAME_FIRST
                                                         : frame_counter + FRAME_BITS'(1);
        end else begin
          change_count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tile_id       <= head.tile;
      tile_changed  <= head.changed;
      frame_done    <= head.frame_end;
      frame_changes <= head.frame_end ? count_next : '0;
      frame_number  <= frame_counter;
    end
  end

endmodule

[src/dirty_tile_detector.sv]
// Top level of the dirty tile detector.
//
// Input channel: one byte of tile data per transaction, tagged with its tile
// number and byte offset, taken when push is high and full is low.
// Result channel: one result per tile, given on the last byte of the tile,
// shown while empty is low and taken when pop is high.
// A result passes through the compare stage, the record queue and the result register.
// The block takes one byte per cycle while full is low; the byte store is read and written in
// the same cycle, so consecutive bytes never wait on each other.
// After reset the block sweeps the tile valid bits, one tile per cycle, over all
// 1024 tiles, and holds full high during the sweep.
// When the receiver stalls, results collect in a four-entry queue behind the
// result register, and full rises once that queue is claimed; no result is
// lost or repeated.
// Each result carries the frame number; the one that closes a frame also
// carries the count of changed tiles in that frame.
module dirty_tile_detector
  import dtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [TILE_BITS-1:0]  tile_number,
  input  logic [BYTE_BITS-1:0]  byte_offset,
  input  logic [DATA_BITS-1:0]  pixel_byte,
  input  logic                  tile_end,
  input  logic                  frame_end,
  output logic                  empty,
  input  logic                  pop,
  output logic [TILE_BITS-1:0]  tile_id,
  output logic                  tile_changed,
  output logic                  frame_done,
  output logic [COUNT_BITS-1:0] frame_changes,
  output logic [FRAME_BITS-1:0] frame_number
);

  logic                 rec_push;
  dtd_rec_t             rec;
  dtd_rec_t             head;
  logic                 q_valid;
  logic                 q_pop;
  logic [QCNT_BITS-1:0] q_level;

  dtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .tile_number(tile_number),
    .byte_offset(byte_offset),
    .pixel_byte (pixel_byte),
    .tile_end   (tile_end),
    .frame_end  (frame_end),
    .q_level    (q_level),
    .rec_push   (rec_push),
    .rec        (rec)
  );

  dtd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_rec   (rec),
    .rd_en    (q_pop),
    .head     (head),
    .not_empty(q_valid),
    .level    (q_level)
  );

  dtd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .tile_id      (tile_id),
    .tile_changed (tile_changed),
    .frame_done   (frame_done),
    .frame_changes(frame_changes),
    .frame_number (frame_number)
  );

endmodule

[src/dtd_checker.sv]
// Port-level checks for the dirty tile detector and their binding.
module dtd_checker
  import dtd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  empty,
  input logic                  pop,
  input logic [TILE_BITS-1:0]  tile_id,
  input logic                  tile_changed,
  input logic                  frame_done,
  input logic [COUNT_BITS-1:0] frame_changes,
  input logic [FRAME_BITS-1:0] frame_number
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result shown right after reset.");

  a_count_only_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_done) |-> (frame_changes == '0))
    else $error("Changed tile count given on a result that does not close a frame.");

  a_frame_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (frame_number != '0))
    else $error("Frame number zero on a result.");

  a_frame_advances: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && frame_done) |=> (empty || (frame_number != $past(frame_number))))
    else $error("Frame number did not advance after a frame closed.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(tile_id) && $stable(tile_changed)))
    else $error("Stalled result changed.");

endmodule

bind dirty_tile_detector dtd_checker u_dtd_checker (
  .clk          (clk),
  .rst          (rst),
  .empty        (empty),
  .pop          (pop),
  .tile_id      (tile_id),
  .tile_changed (tile_changed),
  .frame_done   (frame_done),
  .frame_changes(frame_changes),
  .frame_number (frame_number)
);

[verif/tb.sv]
// Testbench for the dirty tile detector: a directed table, then random frames checked by a predictor.
module tb;
  import dtd_pkg::*;

  typedef struct packed {
    logic [TILE_BITS-1:0] tile;
    logic [BYTE_BITS-1:0] offs;
    logic [DATA_BITS-1:0] data;
    logic                 tend;
    logic                 fend;
  } tile_byte_t;

  typedef struct packed {
    logic [TILE_BITS-1:0]  tile;
    logic                  changed;
    logic                  done;
    logic [COUNT_BITS-1:0] count;
    logic [FRAME_BITS-1:0] frame;
  } tile_report_t;

  typedef struct packed {
    tile_byte_t   stim;
    logic         typed;
    tile_report_t want;
  } directed_row_t;

  localparam int NUM_ROWS    = 22;
  localparam int PHASE_ITEMS = 290;
  localparam int HOLD_ITEMS  = 48;

  directed_row_t rows [NUM_ROWS] = '{
    '{'{10'd0,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1, '{10'd0,    1'b1, 1'b0, 11'd0, 32'd1}},
    '{'{10'd1023, 8'd255, 8'hFF, 1'b1, 1'b0}, 1'b1, '{10'd1023, 1'b1, 1'b0, 11'd0, 32'd1}},
    '{'{10'd0,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1, '{10'd0,    1'b0, 1'b0, 11'd0, 32'd1}},
    '{'{10'd0,    8'd0,   8'hFF, 1'b1, 1'b0}, 1'b1, '{10'd0,    1'b1, 1'b0, 11'd0, 32'd1}},
    '{'{10'd1023, 8'd255, 8'hFF, 1'b0, 1'b1}, 1'b1, '{10'd1023, 1'b0, 1'b1, 11'd3, 32'd1}},
    '{'{10'd5,    8'd0,   8'hA5, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd5,    8'd1,   8'h5A, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd5,    8'd2,   8'h00, 1'b1, 1'b0}, 1'b1, '{10'd5,    1'b1, 1'b0, 11'd0, 32'd2}},
    '{'{10'd5,    8'd0,   8'hA5, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd5,    8'd1,   8'h5A, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd5,    8'd2,   8'h00, 1'b1, 1'b0}, 1'b1, '{10'd5,    1'b0, 1'b0, 11'd0, 32'd2}},
    '{'{10'd5,    8'd0,   8'hA5, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd5,    8'd1,   8'h5B, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd5,    8'd2,   8'h00, 1'b1, 1'b0}, 1'b1, '{10'd5,    1'b1, 1'b0, 11'd0, 32'd2}},
    '{'{10'd5,    8'd0,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd0,    8'd0,   8'hFF, 1'b1, 1'b1}, 1'b1, '{10'd0,    1'b1, 1'b1, 11'd3, 32'd2}},
    '{'{10'd1023, 8'd255, 8'h00, 1'b1, 1'b1}, 1'b1, '{10'd1023, 1'b1, 1'b1, 11'd1, 32'd3}},
    '{'{10'd1023, 8'd255, 8'h00, 1'b1, 1'b1}, 1'b1, '{10'd1023, 1'b0, 1'b1, 11'd0, 32'd4}},
    '{'{10'd512,  8'd128, 8'h81, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd512,  8'd127, 8'h7E, 1'b1, 1'b0}, 1'b0, '0},
    '{'{10'd1,    8'd1,   8'h55, 1'b0, 1'b0}, 1'b0, '0},
    '{'{10'd1,    8'd1,   8'hAA, 1'b1, 1'b0}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic [TILE_BITS-1:0]  tile_number = '0;
  logic [BYTE_BITS-1:0]  byte_offset = '0;
  logic [DATA_BITS-1:0]  pixel_byte = '0;
  logic                  tile_end = 1'b0;
  logic                  frame_end = 1'b0;
  logic                  full;
  logic                  empty;
  logic [TILE_BITS-1:0]  tile_id;
  logic                  tile_changed;
  logic                  frame_done;
  logic [COUNT_BITS-1:0] frame_changes;
  logic [FRAME_BITS-1:0] frame_number;

  logic [DATA_BITS-1:0]  prev_frame [int];
  bit                    tile_seen [NUM_TILES];
  int                    first_off [NUM_TILES];
  int                    tile_len [NUM_TILES];
  bit                    diff_pending = 1'b0;
  logic [COUNT_BITS-1:0] changed_cnt = '0;
  logic [FRAME_BITS-1:0] frame_seq = FRAME_FIRST;

  tile_report_t reports_due [$];
  int err_count = 0;
  int stall_left = 0;
  int send_gap_pct = 0;
  int take_gap_pct = 0;

  dirty_tile_detector u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .tile_number(tile_number),
    .byte_offset(byte_offset),
    .pixel_byte(pixel_byte),
    .tile_end(tile_end),
    .frame_end(frame_end),
    .empty(empty),
    .pop(pop),
    .tile_id(tile_id),
    .tile_changed(tile_changed),
    .frame_done(frame_done),
    .frame_changes(frame_changes),
    .frame_number(frame_number)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string field, input logic [FRAME_BITS-1:0] got,
                               input logic [FRAME_BITS-1:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  task automatic predict_tile_report(input tile_byte_t b, output bit has_rep,
                                     output tile_report_t rep);
    int addr;
    bit was_valid;
    bit chg;
    addr = int'(b.tile) * BYTES_PER_TILE + int'(b.offs);
    was_valid = tile_seen[b.tile];
    has_rep = 1'b0;
    rep = '0;
    if (was_valid && prev_frame[addr] !== b.data) diff_pending = 1'b1;
    prev_frame[addr] = b.data;
    if (first_off[b.tile] < 0) first_off[b.tile] = int'(b.offs);
    if (!b.tend && !b.fend) return;
    chg = !was_valid || diff_pending;
    tile_seen[b.tile] = 1'b1;
    diff_pending = 1'b0;
    if (chg && changed_cnt != COUNT_MAX) changed_cnt++;
    has_rep = 1'b1;
    rep.tile = b.tile;
    rep.changed = chg;
    rep.done = b.fend;
    rep.count = b.fend ? changed_cnt : '0;
    rep.frame = frame_seq;
    if (b.fend) begin
      changed_cnt = '0;
      frame_seq = (frame_seq == FRAME_MAX) ? FRAME_FIRST : frame_seq + FRAME_BITS'(1);
    end
  endtask

  task automatic send_byte(input tile_byte_t b, input logic typed, input tile_report_t want);
    int addr;
    bit has_rep;
    tile_report_t rep;
    addr = int'(b.tile) * BYTES_PER_TILE + int'(b.offs);
    if (tile_seen[b.tile] && !prev_frame.exists(addr)) begin
      b.offs = BYTE_BITS'(first_off[b.tile]);
    end
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    tile_number <= b.tile;
    byte_offset <= b.offs;
    pixel_byte <= b.data;
    tile_end <= b.tend;
    frame_end <= b.fend;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    predict_tile_report(b, has_rep, rep);
    if (has_rep) reports_due.push_back(typed ? want : rep);
  endtask

  task automatic drain_reports();
    push <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send_random_frame(inout int sent);
    int n_tiles;
    int len;
    int t;
    int addr;
    tile_byte_t b;
    n_tiles = $urandom_range(1, 8);
    for (int k = 0; k < n_tiles; k++) begin
      if ($urandom_range(99) < 15) begin
        b.tile = TILE_BITS'($urandom);
        b.offs = BYTE_BITS'($urandom);
        b.data = DATA_BITS'($urandom);
        b.tend = ($urandom_range(99) < 30);
        b.fend = ($urandom_range(99) < 5);
        send_byte(b, 1'b0, '0);
        sent++;
      end else begin
        t = ($urandom_range(99) < 75) ? $urandom_range(0, 15) : $urandom_range(0, NUM_TILES - 1);
        if (tile_len[t] > 0 && $urandom_range(99) < 80) len = tile_len[t];
        else len = ($urandom_range(99) < 90) ? $urandom_range(1, 4) : $urandom_range(5, 24);
        if (tile_len[t] == 0) tile_len[t] = len;
        for (int j = 0; j < len; j++) begin
          addr = t * BYTES_PER_TILE + j;
          b.tile = TILE_BITS'(t);
          b.offs = BYTE_BITS'(j);
          if (prev_frame.exists(addr) && $urandom_range(99) < 90) b.data = prev_frame[addr];
          else b.data = DATA_BITS'($urandom);
          b.tend = (j == len - 1);
          b.fend = (j == len - 1) && (k == n_tiles - 1);
          if (b.fend && $urandom_range(99) < 15) b.tend = 1'b0;
          send_byte(b, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic check_report();
    tile_report_t want;
    if (reports_due.size() == 0) begin
      flag_mismatch("unexpected transaction, tile_id", FRAME_BITS'(tile_id), '0);
      return;
    end
    want = reports_due.pop_front();
    if (tile_id !== want.tile)
      flag_mismatch("tile_id", FRAME_BITS'(tile_id), FRAME_BITS'(want.tile));
    if (tile_changed !== want.changed)
      flag_mismatch("tile_changed", FRAME_BITS'(tile_changed), FRAME_BITS'(want.changed));
    if (frame_done !== want.done)
      flag_mismatch("frame_done", FRAME_BITS'(frame_done), FRAME_BITS'(want.done));
    if (frame_changes !== want.count)
      flag_mismatch("frame_changes", FRAME_BITS'(frame_changes), FRAME_BITS'(want.count));
    if (frame_number !== want.frame) flag_mismatch("frame_number", frame_number, want.frame);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && empty === 1'b0) check_report();
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL dirty_tile_detector");
    $finish;
  end

  initial begin
    tile_byte_t b;
    int sent;
    for (int i = 0; i < NUM_TILES; i++) begin
      first_off[i] = -1;
      tile_len[i] = 0;
    end
    send_gap_pct = 18;
    take_gap_pct = 84;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_byte(rows[i].stim, rows[i].typed, rows[i].want);
    sent = 0;
    while (sent < PHASE_ITEMS) send_random_frame(sent);
    drain_reports();

    send_gap_pct = 84;
    take_gap_pct = 18;
    sent = 0;
    while (sent < PHASE_ITEMS) send_random_frame(sent);
    drain_reports();

    send_gap_pct = 0;
    take_gap_pct = 0;
    sent = 0;
    while (sent < PHASE_ITEMS) send_random_frame(sent);

    // Long receiver stall while every transaction closes a tile, so the result queue fills.
    stall_left = 400;
    for (int i = 0; i < HOLD_ITEMS; i++) begin
      b.tile = TILE_BITS'($urandom_range(0, 31));
      b.offs = '0;
      b.data = DATA_BITS'($urandom);
      b.tend = 1'b1;
      b.fend = 1'b0;
      send_byte(b, 1'b0, '0);
    end
    drain_reports();

    if (err_count == 0) $display("PASS dirty_tile_detector");
    else $display("FAIL dirty_tile_detector");
    $finish;
  end

endmodule
